FILE: sv/spbl_pkg.sv
`default_nettype none

package spbl_pkg;

  // strip geometry
  localparam int LED_COUNT   = 256;
  localparam int NUM_BANDS   = 16;
  localparam int STRIPE_FULL = LED_COUNT / NUM_BANDS;
  localparam int STRIPE_HALF = LED_COUNT / (2 * NUM_BANDS);

  // position counters are at least as wide as the 8-bit index fields
  localparam int LED_W = $clog2(LED_COUNT);
  localparam int POS_W = (LED_W > 8) ? LED_W : 8;
  // stripe countdown holds up to STRIPE_FULL-1
  localparam int CNT_W = ($clog2(STRIPE_FULL) > 0) ? $clog2(STRIPE_FULL) : 1;

  localparam logic [POS_W-1:0] STRIPE_FULL_POS = POS_W'(STRIPE_FULL);
  localparam logic [POS_W-1:0] STRIPE_HALF_POS = POS_W'(STRIPE_HALF);
  localparam logic [POS_W-1:0] LAST_LED        = POS_W'(LED_COUNT - 1);
  localparam logic [CNT_W-1:0] STRIPE_FULL_M1  = CNT_W'(STRIPE_FULL - 1);
  localparam logic [CNT_W-1:0] STRIPE_HALF_M1  = CNT_W'(STRIPE_HALF - 1);

  // blend arithmetic
  localparam logic [3:0]  TOP_BAND = 4'd15;
  // ceil(2^16 / 15), exact floor(y / 15) for y below 4096
  localparam logic [12:0] RECIP_15 = 13'd4370;

  // configuration register indexes
  localparam logic [2:0] REG_COLOR_A_RED   = 3'd0;
  localparam logic [2:0] REG_COLOR_A_GREEN = 3'd1;
  localparam logic [2:0] REG_COLOR_A_BLUE  = 3'd2;
  localparam logic [2:0] REG_COLOR_B_RED   = 3'd3;
  localparam logic [2:0] REG_COLOR_B_GREEN = 3'd4;
  localparam logic [2:0] REG_COLOR_B_BLUE  = 3'd5;
  localparam logic [2:0] REG_MIRROR_MODE   = 3'd6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [3:0] band_index;
    logic [7:0] band_level;
  } band_item_t;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] mirror_index;
    logic       mirror_valid;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       stripe_last;
  } pixel_item_t;

  // finished band color handed from the blend pipeline to the stripe stage
  typedef struct packed {
    logic [3:0] band;
    rgb_t       color;
  } blend_t;

endpackage

`default_nettype wire

FILE: sv/spbl_blend.sv
`default_nettype none

module spbl_blend (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spbl_pkg::band_item_t in_item,
  input  wire spbl_pkg::rgb_t      color_a,
  input  wire spbl_pkg::rgb_t      color_b,
  output logic                     out_valid,
  input  wire logic                out_take,
  output spbl_pkg::blend_t         out_item
);
  import spbl_pkg::*;

  // floor(x / 255) for x up to 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // floor(y / 15) for y below 4096
  function automatic logic [7:0] div15(input logic [11:0] y);
    logic [24:0] p;
    p = 25'(y) * 25'(RECIP_15);
    return p[23:16];
  endfunction

  logic [7:0] ca [3];
  logic [7:0] cb [3];

  assign ca[0] = color_a.red;
  assign ca[1] = color_a.green;
  assign ca[2] = color_a.blue;
  assign cb[0] = color_b.red;
  assign cb[1] = color_b.green;
  assign cb[2] = color_b.blue;

  logic        v1, v2, v3, v4, v5;
  logic        rdy1, rdy2, rdy3, rdy4, rdy5;
  logic [3:0]  k1, k2, k3, k4, k5;
  logic [15:0] pa1 [3];
  logic [15:0] pb1 [3];
  logic [7:0]  qa2 [3];
  logic [7:0]  qb2 [3];
  logic [11:0] ya3 [3];
  logic [11:0] yb3 [3];
  logic [7:0]  za4 [3];
  logic [7:0]  zb4 [3];
  logic [7:0]  sum5 [3];

  // a stage loads when empty or when the one after it moves on
  assign rdy5 = !v5 || out_take;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      k1 <= in_item.band_index;
      for (int c = 0; c < 3; c++) begin
        pa1[c] <= 16'(ca[c]) * 16'(in_item.band_level);
        pb1[c] <= 16'(cb[c]) * 16'(in_item.band_level);
      end
    end
    if (rdy2 && v1) begin
      k2 <= k1;
      for (int c = 0; c < 3; c++) begin
        qa2[c] <= div255(pa1[c]);
        qb2[c] <= div255(pb1[c]);
      end
    end
    if (rdy3 && v2) begin
      k3 <= k2;
      for (int c = 0; c < 3; c++) begin
        ya3[c] <= 12'(qa2[c]) * 12'(TOP_BAND - k2);
        yb3[c] <= 12'(qb2[c]) * 12'(k2);
      end
    end
    if (rdy4 && v3) begin
      k4 <= k3;
      for (int c = 0; c < 3; c++) begin
        za4[c] <= div15(ya3[c]);
        zb4[c] <= div15(yb3[c]);
      end
    end
    if (rdy5 && v4) begin
      k5 <= k4;
      for (int c = 0; c < 3; c++) begin
        sum5[c] <= za4[c] + zb4[c];
      end
    end
  end

  assign out_valid            = v5;
  assign out_item.band        = k5;
  assign out_item.color.red   = sum5[0];
  assign out_item.color.green = sum5[1];
  assign out_item.color.blue  = sum5[2];

endmodule

`default_nettype wire

FILE: sv/spbl_stripe.sv
`default_nettype none

module spbl_stripe (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_take,
  input  wire spbl_pkg::blend_t     src_item,
  input  wire logic                 mirror_mode,
  output logic                      pixel_valid,
  input  wire logic                 pixel_stall,
  output spbl_pkg::pixel_item_t     pixel_item
);
  import spbl_pkg::*;

  logic             busy;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] mpos;
  logic [CNT_W-1:0] remain;
  logic             mir;
  rgb_t             color;

  logic             advance;
  logic             at_last;
  logic [POS_W-1:0] width_sel;
  logic [POS_W-1:0] base;

  assign at_last  = (remain == '0);
  assign advance  = busy && !pixel_stall;
  assign src_take = src_valid && (!busy || (advance && at_last));

  always_comb begin
    width_sel = mirror_mode ? STRIPE_HALF_POS : STRIPE_FULL_POS;
    base      = POS_W'(src_item.band) * width_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (src_take) begin
      busy <= 1'b1;
    end else if (advance && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      pos    <= base;
      mpos   <= LAST_LED - base;
      remain <= mirror_mode ? STRIPE_HALF_M1 : STRIPE_FULL_M1;
      mir    <= mirror_mode;
      color  <= src_item.color;
    end else if (advance && !at_last) begin
      pos    <= pos + POS_W'(1);
      mpos   <= mpos - POS_W'(1);
      remain <= remain - CNT_W'(1);
    end
  end

  assign pixel_valid             = busy;
  assign pixel_item.led_index    = pos[7:0];
  assign pixel_item.mirror_index = mir ? mpos[7:0] : 8'd0;
  assign pixel_item.mirror_valid = mir;
  assign pixel_item.pixel_red    = color.red;
  assign pixel_item.pixel_green  = color.green;
  assign pixel_item.pixel_blue   = color.blue;
  assign pixel_item.stripe_last  = at_last;

endmodule

`default_nettype wire

FILE: sv/spectrum_bar_led_renderer.sv
// timing: first pixel of a band is presented once it has passed the five blend stages and
//   been loaded into the stripe stage, then one pixel per cycle while the output is not stalled
// throughput: the stripe stage emits one pixel a cycle while not stalled, STRIPE_FULL pixels
//   a band (STRIPE_HALF in mirror mode); the five-stage blend pipeline takes a band every
//   cycle while not stalled and keeps up to five more bands queued behind the stripe stage
// reset (synchronous, active high): pipeline and output empty, colors back to defaults
`default_nettype none

module spectrum_bar_led_renderer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // band input channel
  input  wire logic                  band_valid,
  output logic                       band_stall,
  input  wire spbl_pkg::band_item_t  band,
  // pixel output channel
  output logic                       pixel_valid,
  input  wire logic                  pixel_stall,
  output spbl_pkg::pixel_item_t      pixel,
  // register write port
  input  wire logic                  cfg_write,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import spbl_pkg::*;

  // configuration registers; the user must write them only while no band is in flight (not enforced here)
  rgb_t color_a;
  rgb_t color_b;
  logic mirror_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_a     <= '{red: 8'd0, green: 8'd0, blue: 8'd0};
      color_b     <= '{red: 8'd255, green: 8'd0, blue: 8'd0};
      mirror_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLOR_A_RED:   color_a.red   <= cfg_data;
        REG_COLOR_A_GREEN: color_a.green <= cfg_data;
        REG_COLOR_A_BLUE:  color_a.blue  <= cfg_data;
        REG_COLOR_B_RED:   color_b.red   <= cfg_data;
        REG_COLOR_B_GREEN: color_b.green <= cfg_data;
        REG_COLOR_B_BLUE:  color_b.blue  <= cfg_data;
        REG_MIRROR_MODE:   mirror_mode   <= cfg_data[0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // blend pipeline: level scaling, divide by 255, band weighting, divide by 15, sum
  logic   blend_valid;
  logic   blend_take;
  blend_t blend_item;

  spbl_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (band_valid),
    .in_stall  (band_stall),
    .in_item   (band),
    .color_a   (color_a),
    .color_b   (color_b),
    .out_valid (blend_valid),
    .out_take  (blend_take),
    .out_item  (blend_item)
  );

  // stripe stage: holds one band color and walks its led positions, one transfer a pixel;
  // the next band is loaded in the same cycle the last pixel transfers out
  spbl_stripe u_stripe (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (blend_valid),
    .src_take    (blend_take),
    .src_item    (blend_item),
    .mirror_mode (mirror_mode),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_item  (pixel)
  );

endmodule

`default_nettype wire
